// ----- hw/rtl/cell_balance_charge_stage_defines.svh -----
// Assertion helpers for the charge stage block.
// Each expects clk and arst_n in the scope where it is used.
`ifndef CELL_BALANCE_CHARGE_STAGE_DEFINES_SVH
`define CELL_BALANCE_CHARGE_STAGE_DEFINES_SVH

// same-cycle implication
`define CBCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cbcs_pkg.sv -----
package cbcs_pkg;

	localparam int CELL_COUNT = 4;
	localparam int CELL_W     = 13;
	localparam int SUM_W      = 16;
	localparam int GAP_W      = 10;
	localparam int STAGE_W    = 3;
	localparam int BYP_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// charge stages
	localparam logic [STAGE_W-1:0] STAGE_ABSENT    = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_IMBAL     = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_ABNORMAL  = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_PRECHARGE = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_CC        = 3'd4;
	localparam logic [STAGE_W-1:0] STAGE_CV        = 3'd5;

	// bypass codes
	localparam logic [BYP_W-1:0] BYP_NONE  = 2'd0;
	localparam logic [BYP_W-1:0] BYP_INNER = 2'd1;
	localparam logic [BYP_W-1:0] BYP_OUTER = 2'd2;
	localparam logic [BYP_W-1:0] BYP_BOTH  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PACK_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_FULL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_FULL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_RELEASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_GAP     = 3'd5;

	typedef logic [CELL_COUNT-1:0][CELL_W-1:0] cell_vec_t;
	typedef logic [CELL_COUNT-1:0][BYP_W-1:0]  byp_vec_t;

	typedef struct packed {
		logic [SUM_W-1:0]  pack_low;
		logic [SUM_W-1:0]  pack_full;
		logic [CELL_W-1:0] cell_full;
		logic [GAP_W-1:0]  spread_start;
		logic [GAP_W-1:0]  spread_release;
		logic [GAP_W-1:0]  outer_gap;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [CELL_W-1:0] vmax;
		logic [CELL_W-1:0] spread;
	} stats_t;

endpackage

// ----- hw/rtl/cbcs_ifs.sv -----
interface cbcs_sample_if;
	logic        valid;
	logic        ready;
	logic [12:0] cell0_mv;
	logic [12:0] cell1_mv;
	logic [12:0] cell2_mv;
	logic [12:0] cell3_mv;
	logic        abnormal;

	modport source (output valid, cell0_mv, cell1_mv, cell2_mv, cell3_mv, abnormal,
		input ready);
	modport sink (input valid, cell0_mv, cell1_mv, cell2_mv, cell3_mv, abnormal,
		output ready);
endinterface

interface cbcs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] stage;
	logic       imbalance_flag;
	logic [1:0] bypass0;
	logic [1:0] bypass1;
	logic [1:0] bypass2;
	logic [1:0] bypass3;

	modport source (output valid, stage, imbalance_flag, bypass0, bypass1, bypass2,
		bypass3, input ready);
	modport sink (input valid, stage, imbalance_flag, bypass0, bypass1, bypass2,
		bypass3, output ready);
endinterface

// ----- hw/rtl/cbcs_cfg.sv -----
module cbcs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cbcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output cbcs_pkg::cfg_t                      cfg
);

	cbcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pack_low       <= 16'd12400;
			cfg_q.pack_full      <= 16'd16400;
			cfg_q.cell_full      <= 13'd4100;
			cfg_q.spread_start   <= 10'd20;
			cfg_q.spread_release <= 10'd5;
			cfg_q.outer_gap      <= 10'd80;
		end else if (cfg_we) begin
			case (cfg_index)
				cbcs_pkg::REG_PACK_LOW:       cfg_q.pack_low       <= cfg_data;
				cbcs_pkg::REG_PACK_FULL:      cfg_q.pack_full      <= cfg_data;
				cbcs_pkg::REG_CELL_FULL:      cfg_q.cell_full      <= cfg_data[12:0];
				cbcs_pkg::REG_SPREAD_START:   cfg_q.spread_start   <= cfg_data[9:0];
				cbcs_pkg::REG_SPREAD_RELEASE: cfg_q.spread_release <= cfg_data[9:0];
				cbcs_pkg::REG_OUTER_GAP:      cfg_q.outer_gap      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/cbcs_stats.sv -----
module cbcs_stats (
	input  cbcs_pkg::cell_vec_t cells,
	input  cbcs_pkg::cfg_t      cfg,
	output cbcs_pkg::stats_t    stats,
	output cbcs_pkg::byp_vec_t  bypass
);

	logic [cbcs_pkg::SUM_W-1:0]  sum;
	logic [cbcs_pkg::CELL_W-1:0] vmax;
	logic [cbcs_pkg::CELL_W-1:0] vmin;
	logic [cbcs_pkg::CELL_W-1:0] excess;
	logic [cbcs_pkg::GAP_W:0]    both_lim;

	always_comb begin
		sum  = '0;
		vmax = '0;
		vmin = '1;
		for (int i = 0; i < cbcs_pkg::CELL_COUNT; i++) begin
			sum = sum + {{(cbcs_pkg::SUM_W-cbcs_pkg::CELL_W){1'b0}}, cells[i]};
			if (cells[i] > vmax)
				vmax = cells[i];
			if (cells[i] < vmin)
				vmin = cells[i];
		end
	end

	assign stats.sum    = sum;
	assign stats.vmax   = vmax;
	assign stats.spread = vmax - vmin;

	assign both_lim = {1'b0, cfg.outer_gap} + {1'b0, cfg.spread_start};

	always_comb begin
		excess = '0;
		for (int i = 0; i < cbcs_pkg::CELL_COUNT; i++) begin
			excess = cells[i] - vmin;
			if (excess > {2'b0, both_lim})
				bypass[i] = cbcs_pkg::BYP_BOTH;
			else if (excess > {3'b0, cfg.outer_gap})
				bypass[i] = cbcs_pkg::BYP_OUTER;
			else if (excess >= {3'b0, cfg.spread_release})
				bypass[i] = cbcs_pkg::BYP_INNER;
			else
				bypass[i] = cbcs_pkg::BYP_NONE;
		end
	end

endmodule

// ----- hw/rtl/cbcs_stage.sv -----
module cbcs_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  cbcs_pkg::cfg_t                    cfg,
	input  cbcs_pkg::stats_t                  stats,
	input  logic                              abnormal,
	output logic [cbcs_pkg::STAGE_W-1:0]      stage,
	output logic                              flag
);

	logic                         imbal_held_q;
	logic [cbcs_pkg::STAGE_W-1:0] prev_stage_q;
	logic                         above_low;
	logic                         over_full;
	logic                         sticky_cv;

	assign above_low = stats.sum >= cfg.pack_low;
	assign over_full = stats.sum > cfg.pack_full;
	assign sticky_cv = prev_stage_q == cbcs_pkg::STAGE_CV;

	assign flag = (stats.sum > cfg.pack_low && stats.vmax > cfg.cell_full
			&& stats.spread >= {3'b0, cfg.spread_start})
		|| (imbal_held_q && stats.spread >= {3'b0, cfg.spread_release});

	// later rules override earlier ones
	always_comb begin
		stage = cbcs_pkg::STAGE_ABSENT;
		if (above_low && flag)
			stage = cbcs_pkg::STAGE_IMBAL;
		if (abnormal)
			stage = cbcs_pkg::STAGE_ABNORMAL;
		if (!above_low && !abnormal)
			stage = cbcs_pkg::STAGE_PRECHARGE;
		if (above_low && !over_full && !flag && !abnormal && !sticky_cv)
			stage = cbcs_pkg::STAGE_CC;
		if ((over_full || sticky_cv) && !flag && !abnormal)
			stage = cbcs_pkg::STAGE_CV;
		if (stats.sum == '0)
			stage = cbcs_pkg::STAGE_ABSENT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imbal_held_q <= 1'b0;
			prev_stage_q <= cbcs_pkg::STAGE_ABSENT;
		end else if (advance) begin
			imbal_held_q <= flag;
			prev_stage_q <= stage;
		end
	end

endmodule

// ----- hw/rtl/cell_balance_charge_stage.sv -----
// Charge stage selector with passive balancing for a four cell pack.
// sample channel: one item per reading of the four cell voltages (mV) and
// the external abnormal flag. result channel: the charge stage, the
// imbalance flag and a two bit bypass code per cell.
// The cfg write port sets the thresholds by index; write it only while
// no item is in flight.
// A sample is registered on acceptance and its result is loaded into the
// output register as the item advances, which waits while a stalled
// result is held. Throughput is one item per cycle when the receiver does
// not stall: the sum, min/max and stage decision for an item fit
// between the input and output registers, and the held flag and previous
// stage update as the item moves on.
// When the receiver stalls, the result holds; the input register takes
// one more sample only if empty, then ready drops until the result is taken.
// Reset clears both valid bits, the held imbalance flag and the previous
// stage (absent), and restores the threshold defaults.
module cell_balance_charge_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	cbcs_sample_if.sink                        sample,
	cbcs_result_if.source                      result,
	input  logic                               cfg_we,
	input  logic [cbcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	cbcs_pkg::cfg_t      cfg;
	cbcs_pkg::stats_t    stats;
	cbcs_pkg::byp_vec_t  bypass;
	cbcs_pkg::cell_vec_t cells_s1;
	logic                abn_s1;
	logic                vld_s1;
	logic                advance;
	logic [cbcs_pkg::STAGE_W-1:0] stage;
	logic                flag;

	logic                         vld_s2;
	logic [cbcs_pkg::STAGE_W-1:0] stage_s2;
	logic                         flag_s2;
	cbcs_pkg::byp_vec_t           bypass_s2;

	assign advance      = vld_s1 && (!vld_s2 || result.ready);
	assign sample.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (sample.ready)
			vld_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			cells_s1 <= {sample.cell3_mv, sample.cell2_mv, sample.cell1_mv,
				sample.cell0_mv};
			abn_s1   <= sample.abnormal;
		end
	end

	cbcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cbcs_stats u_stats (
		.cells  (cells_s1),
		.cfg    (cfg),
		.stats  (stats),
		.bypass (bypass)
	);

	cbcs_stage u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cfg      (cfg),
		.stats    (stats),
		.abnormal (abn_s1),
		.stage    (stage),
		.flag     (flag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (!vld_s2 || result.ready)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_s2  <= stage;
			flag_s2   <= flag;
			bypass_s2 <= bypass;
		end
	end

	assign result.valid          = vld_s2;
	assign result.stage          = stage_s2;
	assign result.imbalance_flag = flag_s2;
	assign result.bypass0        = bypass_s2[0];
	assign result.bypass1        = bypass_s2[1];
	assign result.bypass2        = bypass_s2[2];
	assign result.bypass3        = bypass_s2[3];

endmodule

// ----- hw/rtl/cbcs_checker.sv -----
`include "cell_balance_charge_stage_defines.svh"

module cbcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [2:0] result_stage,
	input logic       result_flag,
	input logic [1:0] result_bypass0,
	input logic [1:0] result_bypass1,
	input logic [1:0] result_bypass2,
	input logic [1:0] result_bypass3
);

	`CBCS_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
	`CBCS_ASSERT_NXT(a_result_stable, result_valid && !result_ready, $stable({result_stage, result_flag, result_bypass0, result_bypass1, result_bypass2, result_bypass3}), "result changed while stalled")
	`CBCS_ASSERT_IMP(a_imbal_has_flag, result_valid && result_stage == cbcs_pkg::STAGE_IMBAL, result_flag, "imbalance stage without flag")
	`CBCS_ASSERT_IMP(a_charge_no_flag, result_valid && (result_stage == cbcs_pkg::STAGE_CC || result_stage == cbcs_pkg::STAGE_CV), !result_flag, "charging stage with imbalance flag set")

endmodule

bind cell_balance_charge_stage cbcs_checker u_cbcs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_stage   (result.stage),
	.result_flag    (result.imbalance_flag),
	.result_bypass0 (result.bypass0),
	.result_bypass1 (result.bypass1),
	.result_bypass2 (result.bypass2),
	.result_bypass3 (result.bypass3)
);

// ----- bench/cell_balance_charge_stage_test.sv -----
module cell_balance_charge_stage_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cbcs_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 280;

	// indexes past the last register, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [STAGE_W-1:0] stage;
		logic               flag;
		byp_vec_t           byp;
	} charge_report_t;

	class charge_stage_tracker;
		cfg_t               thr;
		bit                 imb_held;
		logic [STAGE_W-1:0] last_stage;
		charge_report_t     due_reports[$];
		int                 fault_count;

		function new();
			thr.pack_low       = 16'd12400;
			thr.pack_full      = 16'd16400;
			thr.cell_full      = 13'd4100;
			thr.spread_start   = 10'd20;
			thr.spread_release = 10'd5;
			thr.outer_gap      = 10'd80;
			imb_held    = 1'b0;
			last_stage  = STAGE_ABSENT;
			fault_count = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PACK_LOW:       thr.pack_low       = data;
				REG_PACK_FULL:      thr.pack_full      = data;
				REG_CELL_FULL:      thr.cell_full      = data[CELL_W-1:0];
				REG_SPREAD_START:   thr.spread_start   = data[GAP_W-1:0];
				REG_SPREAD_RELEASE: thr.spread_release = data[GAP_W-1:0];
				REG_OUTER_GAP:      thr.outer_gap      = data[GAP_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_reports.size();
		endfunction

		function void note_sample(cell_vec_t cells, logic abn);
			int                 sum, vmax, vmin, spread, excess, i;
			bit                 flag;
			logic [STAGE_W-1:0] stg;
			charge_report_t     rep;
			sum  = 0;
			vmax = 0;
			vmin = 8191;
			for (i = 0; i < CELL_COUNT; i++) begin
				sum += int'(cells[i]);
				if (int'(cells[i]) > vmax) vmax = int'(cells[i]);
				if (int'(cells[i]) < vmin) vmin = int'(cells[i]);
			end
			spread = vmax - vmin;
			flag = (sum > int'(thr.pack_low) && vmax > int'(thr.cell_full) &&
					spread >= int'(thr.spread_start)) ||
				(imb_held && spread >= int'(thr.spread_release));

			// later rules override earlier ones
			stg = STAGE_ABSENT;
			if (sum >= int'(thr.pack_low) && flag)
				stg = STAGE_IMBAL;
			if (abn)
				stg = STAGE_ABNORMAL;
			if (sum < int'(thr.pack_low) && !abn)
				stg = STAGE_PRECHARGE;
			if (sum >= int'(thr.pack_low) && sum <= int'(thr.pack_full) && !flag && !abn &&
					last_stage != STAGE_CV)
				stg = STAGE_CC;
			if ((sum > int'(thr.pack_full) || last_stage == STAGE_CV) && !flag && !abn)
				stg = STAGE_CV;
			if (sum == 0)
				stg = STAGE_ABSENT;

			imb_held   = flag;
			last_stage = stg;

			rep.stage = stg;
			rep.flag  = flag;
			for (i = 0; i < CELL_COUNT; i++) begin
				excess = int'(cells[i]) - vmin;
				if (excess > int'(thr.outer_gap) + int'(thr.spread_start))
					rep.byp[i] = BYP_BOTH;
				else if (excess > int'(thr.outer_gap))
					rep.byp[i] = BYP_OUTER;
				else if (excess >= int'(thr.spread_release))
					rep.byp[i] = BYP_INNER;
				else
					rep.byp[i] = BYP_NONE;
			end
			due_reports.push_back(rep);
		endfunction

		function void check_report(charge_report_t got);
			charge_report_t want;
			int             i;
			if (due_reports.size() == 0) begin
				$display("%0t: result item with none expected, stage %0d", $time, got.stage);
				fault_count++;
				return;
			end
			want = due_reports.pop_front();
			if (got.stage !== want.stage) begin
				$display("%0t: stage expected %0d actual %0d", $time, want.stage, got.stage);
				fault_count++;
			end
			if (got.flag !== want.flag) begin
				$display("%0t: imbalance_flag expected %0d actual %0d", $time, want.flag,
					got.flag);
				fault_count++;
			end
			for (i = 0; i < CELL_COUNT; i++) begin
				if (got.byp[i] !== want.byp[i]) begin
					$display("%0t: bypass%0d expected %0d actual %0d", $time, i,
						want.byp[i], got.byp[i]);
					fault_count++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cbcs_sample_if sample_ch();
	cbcs_result_if result_ch();

	cell_balance_charge_stage i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	charge_stage_tracker tracker = new();

	int send_idle_pct;
	int take_idle_pct;
	int walk_mv;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		charge_report_t got;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				tracker.note_sample({sample_ch.cell3_mv, sample_ch.cell2_mv,
					sample_ch.cell1_mv, sample_ch.cell0_mv}, sample_ch.abnormal);
			if (result_ch.valid && result_ch.ready) begin
				got.stage  = result_ch.stage;
				got.flag   = result_ch.imbalance_flag;
				got.byp[0] = result_ch.bypass0;
				got.byp[1] = result_ch.bypass1;
				got.byp[2] = result_ch.bypass2;
				got.byp[3] = result_ch.bypass3;
				tracker.check_report(got);
			end
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic cell_vec_t pack4(int a, int b, int c, int d);
		cell_vec_t v;
		v[0] = a[CELL_W-1:0];
		v[1] = b[CELL_W-1:0];
		v[2] = c[CELL_W-1:0];
		v[3] = d[CELL_W-1:0];
		return v;
	endfunction

	function automatic int clamp_cell(int v);
		if (v < 0) return 0;
		if (v > 8191) return 8191;
		return v;
	endfunction

	// mostly a slow walk around the thresholds so stage history and the
	// held flag get exercised; some fully random and empty samples too
	function automatic cell_vec_t draw_cells();
		cell_vec_t c;
		int        roll, cap, tgt, rest, i;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 18) begin
			for (i = 0; i < CELL_COUNT; i++)
				c[i] = CELL_W'($urandom);
			return c;
		end
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: walk_mv = int'(tracker.thr.pack_low) / 4;
				1: walk_mv = int'(tracker.thr.pack_full) / 4;
				2: walk_mv = int'(tracker.thr.cell_full);
				default: walk_mv = int'($urandom_range(0, 8191));
			endcase
		end else begin
			walk_mv += int'($urandom_range(0, 30)) - 15;
		end
		walk_mv = clamp_cell(walk_mv);
		case ($urandom_range(0, 4))
			0: cap = 0;
			1: cap = int'(tracker.thr.spread_release);
			2: cap = int'(tracker.thr.spread_start) + 3;
			3: cap = int'(tracker.thr.outer_gap) + int'(tracker.thr.spread_start) + 20;
			default: cap = 400;
		endcase
		for (i = 0; i < CELL_COUNT; i++)
			c[i] = CELL_W'(clamp_cell(walk_mv + int'($urandom_range(0, cap))));
		// land the sum right on a threshold now and then
		if ($urandom_range(0, 7) == 0) begin
			tgt  = $urandom_range(0, 1) ? int'(tracker.thr.pack_full) : int'(tracker.thr.pack_low);
			rest = int'(c[1]) + int'(c[2]) + int'(c[3]);
			if (tgt >= rest && tgt - rest <= 8191)
				c[0] = CELL_W'(tgt - rest);
		end
		return c;
	endfunction

	task automatic send_sample(input cell_vec_t c, input logic abn);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.cell0_mv <= c[0];
		sample_ch.cell1_mv <= c[1];
		sample_ch.cell2_mv <= c[2];
		sample_ch.cell3_mv <= c[3];
		sample_ch.abnormal <= abn;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// hold the sender until every result is back and the pipe is empty
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(input int ph);
		int low;
		case (ph)
			1: begin
				low = $urandom_range(8000, 16000);
				write_reg(REG_PACK_LOW, CFG_DATA_W'(low));
				write_reg(REG_PACK_FULL, CFG_DATA_W'(low + int'($urandom_range(0, 6000))));
				write_reg(REG_CELL_FULL, CFG_DATA_W'($urandom_range(2500, 4500)));
				write_reg(REG_SPREAD_START, CFG_DATA_W'($urandom_range(0, 100)));
				write_reg(REG_SPREAD_RELEASE, CFG_DATA_W'($urandom_range(0, 50)));
				write_reg(REG_OUTER_GAP, CFG_DATA_W'($urandom_range(0, 200)));
			end
			2: begin
				write_reg(REG_PACK_LOW, '0);
				write_reg(REG_PACK_FULL, '0);
				write_reg(REG_CELL_FULL, '0);
				write_reg(REG_SPREAD_START, '0);
				write_reg(REG_SPREAD_RELEASE, '0);
				write_reg(REG_OUTER_GAP, '0);
			end
			3: begin
				write_reg(REG_PACK_LOW, '1);
				write_reg(REG_PACK_FULL, '1);
				write_reg(REG_CELL_FULL, '1);
				write_reg(REG_SPREAD_START, '1);
				write_reg(REG_SPREAD_RELEASE, '1);
				write_reg(REG_OUTER_GAP, '1);
				write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
			end
			4: begin
				write_reg(REG_PACK_LOW, 16'd12400);
				write_reg(REG_PACK_FULL, 16'd16400);
				write_reg(REG_CELL_FULL, 16'd4100);
				write_reg(REG_SPREAD_START, 16'd20);
				write_reg(REG_SPREAD_RELEASE, 16'd5);
				write_reg(REG_OUTER_GAP, 16'd80);
			end
			default: begin
				// junk in the upper data bits must be dropped
				low = $urandom_range(6000, 18000);
				write_reg(REG_SPREAD_RELEASE,
					CFG_DATA_W'(($urandom & 16'hFC00) | $urandom_range(0, 30)));
				write_reg(REG_OUTER_GAP,
					CFG_DATA_W'(($urandom & 16'hFC00) | $urandom_range(0, 150)));
				write_reg(REG_SPREAD_START,
					CFG_DATA_W'(($urandom & 16'hFC00) | $urandom_range(0, 60)));
				write_reg(REG_CELL_FULL,
					CFG_DATA_W'(($urandom & 16'hE000) | $urandom_range(2000, 5000)));
				write_reg(REG_PACK_FULL, CFG_DATA_W'(low + int'($urandom_range(0, 4000))));
				write_reg(REG_PACK_LOW, CFG_DATA_W'(low));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		send_sample(pack4(0, 0, 0, 0), 1'b0);            // empty pack
		send_sample(pack4(3100, 3100, 3100, 3100), 1'b0); // sum on low threshold
		send_sample(pack4(4100, 4100, 4100, 4100), 1'b0); // sum on full threshold
		send_sample(pack4(3000, 3000, 3000, 3000), 1'b0);
		send_sample(pack4(4101, 4101, 4101, 4101), 1'b0); // into constant voltage
		send_sample(pack4(3000, 3000, 3000, 3000), 1'b0); // sticky below low
		send_sample(pack4(3000, 3000, 3000, 3000), 1'b1);
		send_sample(pack4(3000, 3000, 3000, 3000), 1'b0);
		send_sample(pack4(4150, 4100, 4100, 4100), 1'b0); // flag sets
		send_sample(pack4(4110, 4100, 4100, 4100), 1'b0); // flag holds
		send_sample(pack4(4104, 4100, 4100, 4100), 1'b0); // flag releases
		send_sample(pack4(0, 0, 0, 0), 1'b1);             // empty beats abnormal
		send_sample(pack4(3000, 3005, 3080, 3081), 1'b0); // bypass edges
		send_sample(pack4(3000, 3100, 3101, 3004), 1'b0);
		send_sample(pack4(8191, 0, 0, 0), 1'b0);
		send_sample(pack4(0, 8191, 0, 8191), 1'b1);
		send_sample(pack4(8191, 8191, 8191, 8191), 1'b0);
		send_sample(pack4(0, 0, 1, 0), 1'b0);
		send_sample(pack4(4200, 4200, 4200, 4000), 1'b0);
		send_sample(pack4(4200, 4200, 4200, 4000), 1'b1); // abnormal while flagged
		send_sample(pack4(4200, 4200, 4200, 4200), 1'b0);
		send_sample(pack4(0, 0, 0, 0), 1'b0);
	endtask

	initial begin
		int ph, n;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.cell0_mv <= '0;
		sample_ch.cell1_mv <= '0;
		sample_ch.cell2_mv <= '0;
		sample_ch.cell3_mv <= '0;
		sample_ch.abnormal <= 1'b0;
		send_idle_pct = 23;
		take_idle_pct = 62;
		walk_mv       = 3100;
		quiet_cycles  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				wait_drained();
				configure(ph);
			end
			case (ph / 2)
				0: begin
					send_idle_pct = 23;
					take_idle_pct = 62;
				end
				1: begin
					send_idle_pct = 62;
					take_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			if (ph == 0)
				run_directed();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_sample(draw_cells(), $urandom_range(0, 99) < 8);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (tracker.fault_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cbcs_pkg.sv
hw/rtl/cbcs_ifs.sv
hw/rtl/cbcs_cfg.sv
hw/rtl/cbcs_stats.sv
hw/rtl/cbcs_stage.sv
hw/rtl/cell_balance_charge_stage.sv
hw/rtl/cbcs_checker.sv
bench/cell_balance_charge_stage_test.sv
